// File: sv/lzss_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Ring geometry, match constants and the ring access request.
// ----------------------------------------------------------------------------
package lzss_pkg;

   localparam int RING_SIZE  = 4096;
   localparam int RING_AW    = $clog2(RING_SIZE);
   localparam int MAX_MATCH  = 18;
   localparam int MATCH_BIAS = 2;
   localparam int LEN_W      = $clog2(MAX_MATCH + 1);

   localparam logic [RING_AW-1:0] WP_START   = RING_AW'(RING_SIZE - MAX_MATCH);
   localparam logic [7:0]         SPACE_CHAR = 8'h20;

   typedef logic [RING_AW-1:0] ring_addr_type;

   // Ring traffic of a clock: a write, a read and a clear of the fill state.
   typedef struct packed {
      logic          clear;
      logic          wr_en;
      ring_addr_type wr_addr;
      logic [7:0]    wr_data;
      logic          rd_en;
      ring_addr_type rd_addr;
   } ring_req_type;

endpackage

// File: sv/lzss_ring.sv
// ----------------------------------------------------------------------------
// LZSS history ring
// Single-port-write, single-read synchronous ring with a registered read.
// A fill count stands in for the clear to spaces: writes always advance from
// the start pointer, so the written entries form one contiguous run.
// ----------------------------------------------------------------------------
module lzss_ring
   import lzss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ring_req_type req,
   output logic [7:0]   rd_data
);

   logic [7:0]       mem [RING_SIZE];
   logic [7:0]       mem_q_ff;
   logic             hit_ff;
   logic             hit_in;
   logic             fwd_ff;
   logic             fwd_in;
   logic [7:0]       fwd_data_ff;
   logic [RING_AW:0] fill_ff;
   logic [RING_AW:0] fill_in;
   ring_addr_type    rd_ofs;

   // distance of the read address past the start pointer
   assign rd_ofs = req.rd_addr - WP_START;
   assign hit_in = {1'b0, rd_ofs} < fill_ff;
   // write to the same entry in the same cycle: memory returns old data
   assign fwd_in = req.wr_en && (req.wr_addr == req.rd_addr);

   always_comb begin
      fill_in = fill_ff;
      if (req.clear) begin
         fill_in = '0;
      end else if (req.wr_en && (fill_ff != (RING_AW+1)'(RING_SIZE))) begin
         fill_in = fill_ff + (RING_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         mem_q_ff    <= mem[req.rd_addr];
         hit_ff      <= hit_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? mem_q_ff : SPACE_CHAR);

endmodule

// File: sv/lzss_decompressor.sv
// ----------------------------------------------------------------------------
// LZSS decompressor
// Byte-serial LZSS decoder with a 4096-byte history ring.
// ----------------------------------------------------------------------------
// Takes one compressed byte per transfer and returns the decoded bytes, with
// rsp_tlast set on the last byte produced by each input byte. A flag byte or
// the first byte of a match pair produces no output, a literal one byte, and
// the second byte of a pair a copy of 3 to 18 bytes: while the output queue
// has room, the copy reads and writes back one ring byte per cycle through
// the ring's single read and write port. A byte with req_tlast set ends the
// stream; if it produced output, the block waits until the last ring write
// is done before the ring reads as spaces again. A two-entry output queue
// keeps the copy streaming while the consumer takes one byte per cycle.
// ----------------------------------------------------------------------------
module lzss_decompressor
   import lzss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // compressed stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // last_of_stream
   // decoded bytes
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // last_of_run
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_COPY   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      PH_FLAG = 3'b001,
      PH_UNIT = 3'b010,
      PH_PAIR = 3'b100
   } phase_type;

   state_type     st_ff, st_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    flags_ff, flags_in;
   logic [3:0]    fcnt_ff, fcnt_in;
   logic [7:0]    held_ff, held_in;
   ring_addr_type wp_ff, wp_in;
   ring_addr_type src_ff, src_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic          end_ff, end_in;

   // emit stage: byte written to the ring and pushed to the output queue
   logic          em_valid_ff, em_valid_in;
   logic          em_lit_ff, em_lit_in;
   logic [7:0]    em_lit_byte_ff, em_lit_byte_in;
   logic          em_last_ff, em_last_in;
   logic [7:0]    em_byte;

   // output queue
   logic [7:0]    q_data_ff [2];
   logic          q_last_ff [2];
   logic          q_wr_ff, q_rd_ff;
   logic [1:0]    q_cnt_ff, q_cnt_in;
   logic          pop;
   logic [2:0]    occ;
   logic          room;

   ring_req_type  ring_req;
   logic [7:0]    ring_rd_data;

   logic          req_accept;
   logic          do_reset;
   logic [7:0]    nu_flags;
   logic [3:0]    nu_fcnt;
   phase_type     nu_phase;

   lzss_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .req     (ring_req),
      .rd_data (ring_rd_data)
   );

   assign pop        = rsp_tvalid && rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   // entries held after this edge plus the one the emit stage still owes
   assign occ        = {1'b0, q_cnt_ff} - {2'b00, pop} + {2'b00, em_valid_ff};
   assign room       = occ <= 3'd1;
   assign req_tready = (st_ff == ST_IDLE) && room;

   assign em_byte = em_lit_ff ? em_lit_byte_ff : ring_rd_data;

   // advance to the next unit under the current flag byte
   assign nu_flags = flags_ff >> 1;
   assign nu_fcnt  = (fcnt_ff != 4'd0) ? fcnt_ff - 4'd1 : 4'd0;
   assign nu_phase = (nu_fcnt == 4'd0) ? PH_FLAG : PH_UNIT;

   always_comb begin
      st_in          = st_ff;
      phase_in       = phase_ff;
      flags_in       = flags_ff;
      fcnt_in        = fcnt_ff;
      held_in        = held_ff;
      wp_in          = wp_ff;
      src_in         = src_ff;
      left_in        = left_ff;
      end_in         = end_ff;
      em_valid_in    = 1'b0;
      em_lit_in      = em_lit_ff;
      em_lit_byte_in = em_lit_byte_ff;
      em_last_in     = em_last_ff;
      do_reset       = 1'b0;

      ring_req.clear   = 1'b0;
      ring_req.wr_en   = em_valid_ff;
      ring_req.wr_addr = wp_ff;
      ring_req.wr_data = em_byte;
      ring_req.rd_en   = 1'b0;
      ring_req.rd_addr = src_ff;

      if (em_valid_ff) begin
         wp_in = wp_ff + ring_addr_type'(1);
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (phase_ff)
                  PH_UNIT: begin
                     if (flags_ff[0]) begin
                        em_valid_in    = 1'b1;
                        em_lit_in      = 1'b1;
                        em_lit_byte_in = req_tdata;
                        em_last_in     = 1'b1;
                        flags_in       = nu_flags;
                        fcnt_in        = nu_fcnt;
                        phase_in       = nu_phase;
                        if (req_tlast) begin
                           st_in = ST_FINISH;
                        end
                     end else begin
                        held_in  = req_tdata;
                        phase_in = PH_PAIR;
                        do_reset = req_tlast;
                     end
                  end
                  PH_PAIR: begin
                     src_in   = {req_tdata[7:4], held_ff};
                     left_in  = LEN_W'(req_tdata[3:0]) + LEN_W'(MATCH_BIAS + 1);
                     end_in   = req_tlast;
                     st_in    = ST_COPY;
                     flags_in = nu_flags;
                     fcnt_in  = nu_fcnt;
                     phase_in = nu_phase;
                  end
                  default: begin
                     flags_in = req_tdata;
                     fcnt_in  = 4'd8;
                     phase_in = PH_UNIT;
                     do_reset = req_tlast;
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (room) begin
               ring_req.rd_en = 1'b1;
               em_valid_in    = 1'b1;
               em_lit_in      = 1'b0;
               em_last_in     = (left_ff == LEN_W'(1));
               src_in         = src_ff + ring_addr_type'(1);
               left_in        = left_ff - LEN_W'(1);
               if (left_ff == LEN_W'(1)) begin
                  st_in = end_ff ? ST_FINISH : ST_IDLE;
               end
            end
         end
         ST_FINISH: begin
            if (!em_valid_ff) begin
               do_reset = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // end of stream: back to the start state, ring reads as spaces
      if (do_reset) begin
         ring_req.clear = 1'b1;
         wp_in          = WP_START;
         flags_in       = '0;
         fcnt_in        = '0;
         phase_in       = PH_FLAG;
         held_in        = '0;
      end
   end

   always_comb begin
      q_cnt_in = q_cnt_ff;
      if (em_valid_ff && !pop) begin
         q_cnt_in = q_cnt_ff + 2'd1;
      end else if (!em_valid_ff && pop) begin
         q_cnt_in = q_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         phase_ff    <= PH_FLAG;
         flags_ff    <= '0;
         fcnt_ff     <= '0;
         held_ff     <= '0;
         wp_ff       <= WP_START;
         end_ff      <= 1'b0;
         em_valid_ff <= 1'b0;
         q_wr_ff     <= 1'b0;
         q_rd_ff     <= 1'b0;
         q_cnt_ff    <= '0;
      end else begin
         st_ff       <= st_in;
         phase_ff    <= phase_in;
         flags_ff    <= flags_in;
         fcnt_ff     <= fcnt_in;
         held_ff     <= held_in;
         wp_ff       <= wp_in;
         end_ff      <= end_in;
         em_valid_ff <= em_valid_in;
         q_cnt_ff    <= q_cnt_in;
         if (em_valid_ff) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      left_ff        <= left_in;
      em_lit_ff      <= em_lit_in;
      em_lit_byte_ff <= em_lit_byte_in;
      em_last_ff     <= em_last_in;
      if (em_valid_ff) begin
         q_data_ff[q_wr_ff] <= em_byte;
         q_last_ff[q_wr_ff] <= em_last_ff;
      end
   end

   assign rsp_tvalid = q_cnt_ff != 2'd0;
   assign rsp_tdata  = q_data_ff[q_rd_ff];
   assign rsp_tlast  = q_last_ff[q_rd_ff];

endmodule
